// ----- rtl/edge_loop_filter_core_assert.svh -----
// assertion macros for the edge loop filter
`ifndef EDGE_LOOP_FILTER_CORE_ASSERT_SVH
`define EDGE_LOOP_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define ELF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ELF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next cycle check failed");
`else
`define ELF_ASSERT_IMPLY(label, ante, cons)
`define ELF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/elf_pkg.sv -----
// shared types and constants of the edge loop filter
package elf_pkg;

  typedef logic [7:0] pixel_t;
  typedef logic [1:0] opcode_t;
  typedef logic [1:0] reg_index_t;

  localparam int ADDR_W = 4;

  localparam opcode_t OP_SIMPLE   = 2'd0;
  localparam opcode_t OP_MB_EDGE  = 2'd1;
  localparam opcode_t OP_INNER    = 2'd2;

  localparam reg_index_t REG_EDGE_LIMIT     = 2'd0;
  localparam reg_index_t REG_INTERIOR_LIMIT = 2'd1;
  localparam reg_index_t REG_VAR_THRESHOLD  = 2'd2;

  localparam logic signed [13:0] WIDE_TAP0  = 14'sd27;
  localparam logic signed [13:0] WIDE_TAP1  = 14'sd18;
  localparam logic signed [13:0] WIDE_TAP2  = 14'sd9;
  localparam logic signed [13:0] WIDE_ROUND = 14'sd63;

endpackage

// ----- rtl/elf_in_if.sv -----
// segment channel: edge kind and eight pixels
interface elf_in_if import elf_pkg::*;;
  logic    valid;
  logic    ready;
  opcode_t opcode;
  pixel_t  p3_in;
  pixel_t  p2_in;
  pixel_t  p1_in;
  pixel_t  p0_in;
  pixel_t  q0_in;
  pixel_t  q1_in;
  pixel_t  q2_in;
  pixel_t  q3_in;

  modport source (
    output valid, opcode, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, p3_in, p2_in, p1_in, p0_in, q0_in, q1_in, q2_in, q3_in,
    output ready
  );
endinterface

// ----- rtl/elf_out_if.sv -----
// result channel: six filtered pixels and filter flag
interface elf_out_if import elf_pkg::*;;
  logic   valid;
  logic   ready;
  pixel_t p2_out;
  pixel_t p1_out;
  pixel_t p0_out;
  pixel_t q0_out;
  pixel_t q1_out;
  pixel_t q2_out;
  logic   was_filtered;

  modport source (
    output valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, was_filtered,
    input  ready
  );
  modport sink (
    input  valid, p2_out, p1_out, p0_out, q0_out, q1_out, q2_out, was_filtered,
    output ready
  );
endinterface

// ----- rtl/edge_loop_filter_core.sv -----
// edge loop filter core: four stage pipeline with limit registers
// an accepted word moves through stage registers one to four in turn and is shown on result from stage four
// throughput: one word per cycle while result is not stalled, set by the four register stages with no feedback
// a stalled result holds stage four; earlier stages keep filling until full
// reset (rst, synchronous) clears all stage valid bits and the three limits to 0
`include "edge_loop_filter_core_assert.svh"

module edge_loop_filter_core import elf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  elf_in_if.sink            segment,
  elf_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_COMMON,
    MODE_INNER,
    MODE_WIDE
  } mode_t;

  typedef struct packed {
    opcode_t            op;
    pixel_t             p2;
    pixel_t             p1;
    pixel_t             p0;
    pixel_t             q0;
    pixel_t             q1;
    pixel_t             q2;
    logic               pass_edge;
    logic [7:0]         d_p3p2;
    logic [7:0]         d_p2p1;
    logic [7:0]         d_p1p0;
    logic [7:0]         d_q3q2;
    logic [7:0]         d_q2q1;
    logic [7:0]         d_q1q0;
    logic signed [7:0]  s_pq;
    logic signed [8:0]  dq;
  } stage1_t;

  typedef struct packed {
    opcode_t            op;
    mode_t              mode;
    logic signed [7:0]  filt;
    pixel_t             p2;
    pixel_t             p1;
    pixel_t             p0;
    pixel_t             q0;
    pixel_t             q1;
    pixel_t             q2;
  } stage2_t;

  typedef struct packed {
    logic               filtered;
    logic signed [7:0]  add_p2;
    logic signed [7:0]  add_p1;
    logic signed [7:0]  add_p0;
    logic signed [7:0]  sub_q0;
    logic signed [7:0]  sub_q1;
    logic signed [7:0]  sub_q2;
    pixel_t             p2;
    pixel_t             p1;
    pixel_t             p0;
    pixel_t             q0;
    pixel_t             q1;
    pixel_t             q2;
  } stage3_t;

  typedef struct packed {
    pixel_t p2;
    pixel_t p1;
    pixel_t p0;
    pixel_t q0;
    pixel_t q1;
    pixel_t q2;
    logic   filtered;
  } stage4_t;

  function automatic logic [7:0] absdiff(input pixel_t a, input pixel_t b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [7:0] sat_s8(input logic signed [11:0] v);
    if (v < -12'sd128) begin
      sat_s8 = -8'sd128;
    end else if (v > 12'sd127) begin
      sat_s8 = 8'sd127;
    end else begin
      sat_s8 = v[7:0];
    end
  endfunction

  function automatic pixel_t clamp_pix(input logic signed [9:0] v);
    if (v < 10'sd0) begin
      clamp_pix = 8'd0;
    end else if (v > 10'sd255) begin
      clamp_pix = 8'd255;
    end else begin
      clamp_pix = v[7:0];
    end
  endfunction

  // limit registers and apb port
  logic [7:0] edge_limit;
  logic [5:0] interior_limit;
  logic [5:0] variance_threshold;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_limit         <= '0;
      interior_limit     <= '0;
      variance_threshold <= '0;
    end else if (cfg_write) begin
      unique case (paddr[ADDR_W-1:2])
        REG_EDGE_LIMIT:     edge_limit         <= pwdata[7:0];
        REG_INTERIOR_LIMIT: interior_limit     <= pwdata[5:0];
        REG_VAR_THRESHOLD:  variance_threshold <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_EDGE_LIMIT:     prdata = 32'(edge_limit);
      REG_INTERIOR_LIMIT: prdata = 32'(interior_limit);
      REG_VAR_THRESHOLD:  prdata = 32'(variance_threshold);
      default:            prdata = '0;
    endcase
  end

  // pipeline flow control
  logic    v1, v2, v3, v4;
  logic    adv1, adv2, adv3, adv4;
  stage1_t s1, s1_next;
  stage2_t s2, s2_next;
  stage3_t s3, s3_next;
  stage4_t s4, s4_next;

  assign adv4          = !v4 || result.ready;
  assign adv3          = !v3 || adv4;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign segment.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= segment.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1 <= s1_next;
    if (adv2) s2 <= s2_next;
    if (adv3) s3 <= s3_next;
    if (adv4) s4 <= s4_next;
  end

  // stage 1: differences and edge test
  logic [7:0]        d_p0q0;
  logic [7:0]        d_p1q1;
  logic [9:0]        edge_sum;
  logic signed [8:0] pq_diff;

  always_comb begin
    d_p0q0   = absdiff(segment.p0_in, segment.q0_in);
    d_p1q1   = absdiff(segment.p1_in, segment.q1_in);
    edge_sum = {1'b0, d_p0q0, 1'b0} + {3'b0, d_p1q1[7:1]};
    pq_diff  = $signed({1'b0, segment.p1_in}) - $signed({1'b0, segment.q1_in});

    s1_next.op        = segment.opcode;
    s1_next.p2        = segment.p2_in;
    s1_next.p1        = segment.p1_in;
    s1_next.p0        = segment.p0_in;
    s1_next.q0        = segment.q0_in;
    s1_next.q1        = segment.q1_in;
    s1_next.q2        = segment.q2_in;
    s1_next.pass_edge = edge_sum <= {2'b0, edge_limit};
    s1_next.d_p3p2    = absdiff(segment.p3_in, segment.p2_in);
    s1_next.d_p2p1    = absdiff(segment.p2_in, segment.p1_in);
    s1_next.d_p1p0    = absdiff(segment.p1_in, segment.p0_in);
    s1_next.d_q3q2    = absdiff(segment.q3_in, segment.q2_in);
    s1_next.d_q2q1    = absdiff(segment.q2_in, segment.q1_in);
    s1_next.d_q1q0    = absdiff(segment.q1_in, segment.q0_in);
    s1_next.s_pq      = sat_s8(12'(pq_diff));
    s1_next.dq        = $signed({1'b0, segment.q0_in}) - $signed({1'b0, segment.p0_in});
  end

  // stage 2: interior and variance tests, filter mode, base value
  logic               int_ok;
  logic               high_var;
  logic [7:0]         i_lim;
  logic [7:0]         t_lim;
  logic signed [11:0] dq12;
  logic signed [11:0] dq_x3;
  logic signed [7:0]  a_hv;
  logic signed [7:0]  a_in;

  always_comb begin
    i_lim    = 8'(interior_limit);
    t_lim    = 8'(variance_threshold);
    int_ok   = (s1.d_p3p2 <= i_lim) && (s1.d_p2p1 <= i_lim) && (s1.d_p1p0 <= i_lim) &&
               (s1.d_q3q2 <= i_lim) && (s1.d_q2q1 <= i_lim) && (s1.d_q1q0 <= i_lim);
    high_var = (s1.d_p1p0 > t_lim) || (s1.d_q1q0 > t_lim);
    dq12     = 12'(s1.dq);
    dq_x3    = (dq12 <<< 1) + dq12;
    a_hv     = sat_s8(dq_x3 + 12'(s1.s_pq));
    a_in     = sat_s8(dq_x3);

    s2_next.op   = s1.op;
    s2_next.p2   = s1.p2;
    s2_next.p1   = s1.p1;
    s2_next.p0   = s1.p0;
    s2_next.q0   = s1.q0;
    s2_next.q1   = s1.q1;
    s2_next.q2   = s1.q2;
    s2_next.mode = MODE_NONE;
    unique case (s1.op)
      OP_SIMPLE: begin
        if (s1.pass_edge) s2_next.mode = MODE_COMMON;
      end
      OP_MB_EDGE: begin
        if (s1.pass_edge && int_ok) s2_next.mode = high_var ? MODE_COMMON : MODE_WIDE;
      end
      OP_INNER: begin
        if (s1.pass_edge && int_ok) s2_next.mode = high_var ? MODE_COMMON : MODE_INNER;
      end
      default: s2_next.mode = MODE_NONE;
    endcase
    s2_next.filt = (s2_next.mode == MODE_INNER) ? a_in : a_hv;
  end

  // stage 3: filter taps per pixel
  logic signed [8:0]  fa4;
  logic signed [8:0]  fa3;
  logic signed [7:0]  f1;
  logic signed [7:0]  f2;
  logic signed [7:0]  t1;
  logic signed [13:0] wx;
  logic signed [13:0] w0;
  logic signed [13:0] w1;
  logic signed [13:0] w2;

  always_comb begin
    fa4 = 9'(s2.filt) + 9'sd4;
    if (fa4 > 9'sd127) fa4 = 9'sd127;
    fa3 = 9'(s2.filt) + 9'sd3;
    if (fa3 > 9'sd127) fa3 = 9'sd127;
    f1 = 8'(fa4 >>> 3);
    f2 = 8'(fa3 >>> 3);
    t1 = (f1 + 8'sd1) >>> 1;
    wx = 14'(s2.filt);
    w0 = (wx * WIDE_TAP0 + WIDE_ROUND) >>> 7;
    w1 = (wx * WIDE_TAP1 + WIDE_ROUND) >>> 7;
    w2 = (wx * WIDE_TAP2 + WIDE_ROUND) >>> 7;

    s3_next.p2       = s2.p2;
    s3_next.p1       = s2.p1;
    s3_next.p0       = s2.p0;
    s3_next.q0       = s2.q0;
    s3_next.q1       = s2.q1;
    s3_next.q2       = s2.q2;
    s3_next.filtered = s2.mode != MODE_NONE;
    s3_next.add_p2   = '0;
    s3_next.add_p1   = '0;
    s3_next.add_p0   = '0;
    s3_next.sub_q0   = '0;
    s3_next.sub_q1   = '0;
    s3_next.sub_q2   = '0;
    case (s2.mode)
      MODE_COMMON: begin
        s3_next.add_p0 = f2;
        s3_next.sub_q0 = f1;
      end
      MODE_INNER: begin
        s3_next.add_p0 = f2;
        s3_next.sub_q0 = f1;
        s3_next.add_p1 = t1;
        s3_next.sub_q1 = t1;
      end
      MODE_WIDE: begin
        s3_next.add_p0 = 8'(w0);
        s3_next.sub_q0 = 8'(w0);
        s3_next.add_p1 = 8'(w1);
        s3_next.sub_q1 = 8'(w1);
        s3_next.add_p2 = 8'(w2);
        s3_next.sub_q2 = 8'(w2);
      end
      default: ;
    endcase
  end

  // stage 4: apply and clamp
  always_comb begin
    s4_next.p2 = clamp_pix($signed({2'b0, s3.p2}) + 10'(s3.add_p2));
    s4_next.p1 = clamp_pix($signed({2'b0, s3.p1}) + 10'(s3.add_p1));
    s4_next.p0 = clamp_pix($signed({2'b0, s3.p0}) + 10'(s3.add_p0));
    s4_next.q0 = clamp_pix($signed({2'b0, s3.q0}) - 10'(s3.sub_q0));
    s4_next.q1 = clamp_pix($signed({2'b0, s3.q1}) - 10'(s3.sub_q1));
    s4_next.q2 = clamp_pix($signed({2'b0, s3.q2}) - 10'(s3.sub_q2));
    s4_next.filtered = s3.filtered;
  end

  assign result.valid        = v4;
  assign result.p2_out       = s4.p2;
  assign result.p1_out       = s4.p1;
  assign result.p0_out       = s4.p0;
  assign result.q0_out       = s4.q0;
  assign result.q1_out       = s4.q1;
  assign result.q2_out       = s4.q2;
  assign result.was_filtered = s4.filtered;

  `ELF_ASSERT_IMPLY(a_full_stall, v1 && v2 && v3 && v4 && !result.ready, !segment.ready)
  `ELF_ASSERT_NEXT(a_stage_moves, v1 && adv2, v2)
  `ELF_ASSERT_IMPLY(a_simple_mode, v2 && s2.op == OP_SIMPLE, s2.mode == MODE_NONE || s2.mode == MODE_COMMON)
  `ELF_ASSERT_IMPLY(a_unfiltered_zero, v3 && !s3.filtered, s3.add_p0 == 8'sd0 && s3.sub_q0 == 8'sd0 && s3.add_p2 == 8'sd0)

endmodule

// ----- sim/edge_loop_filter_core_tb.sv -----
// self-checking testbench of the edge loop filter core: segment stimulus, limit writes, checks
module edge_loop_filter_core_tb;
  import elf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam opcode_t OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 64;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES = 7;
  // -1 picks a random limit
  localparam int LIMIT_SETS[PHASES][3] = '{
    '{255, 63, 63}, '{255, 63, 0}, '{60, 12, 4}, '{15, 3, 1},
    '{-1, -1, -1}, '{-1, -1, -1}, '{0, 0, 0}
  };
  localparam string PIX_NAME[6] = '{"q2", "q1", "q0", "p0", "p1", "p2"};

  typedef struct packed {
    opcode_t          op;
    pixel_t [7:0]     pix;   // p3 p2 p1 p0 q0 q1 q2 q3, p3 in the top byte
  } seg_word_t;

  typedef struct packed {
    pixel_t [5:0] pix;       // p2 p1 p0 q0 q1 q2, p2 in the top byte
    logic         filtered;
  } seg_result_t;

  typedef enum {FK_NONE, FK_COMMON, FK_INNER, FK_WIDE} filter_kind_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  elf_in_if  seg_ch();
  elf_out_if res_ch();

  edge_loop_filter_core dut (
    .clk, .rst, .segment(seg_ch), .result(res_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  int unsigned edge_lim = 0;
  int unsigned int_lim = 0;
  int unsigned hev_thr = 0;

  seg_word_t   word_queue[$];
  seg_result_t expected_results[$];
  seg_word_t   cur_word;
  seg_result_t got, want;
  int          src_gap, hold_left, idle_cycles, mismatches;
  bit          src_steady, snk_steady, long_hold_req, long_hold_done;

  function automatic int sat8(int v);
    return v < -128 ? -128 : (v > 127 ? 127 : v);
  endfunction

  function automatic int clamp_pix(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int absd(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic seg_result_t filter_segment(seg_word_t w);
    int p3 = w.pix[7], p2 = w.pix[6], p1 = w.pix[5], p0 = w.pix[4];
    int q0 = w.pix[3], q1 = w.pix[2], q2 = w.pix[1], q3 = w.pix[0];
    int o_p2 = p2, o_p1 = p1, o_p0 = p0, o_q0 = q0, o_q1 = q1, o_q2 = q2;
    int a, f1, f2, t, wv, a0, a1, a2;
    bit edge_ok, interior_ok, hev;
    filter_kind_t kind = FK_NONE;
    seg_result_t r;
    edge_ok = 2 * absd(p0, q0) + (absd(p1, q1) >> 1) <= int'(edge_lim);
    hev = absd(p1, p0) > int'(hev_thr) || absd(q1, q0) > int'(hev_thr);
    interior_ok = absd(p3, p2) <= int'(int_lim) && absd(p2, p1) <= int'(int_lim) &&
                  absd(p1, p0) <= int'(int_lim) && absd(q3, q2) <= int'(int_lim) &&
                  absd(q2, q1) <= int'(int_lim) && absd(q1, q0) <= int'(int_lim);
    case (w.op)
      OP_SIMPLE: if (edge_ok) kind = FK_COMMON;
      OP_MB_EDGE, OP_INNER: begin
        if (edge_ok && interior_ok) begin
          if (hev) kind = FK_COMMON;
          else kind = (w.op == OP_MB_EDGE) ? FK_WIDE : FK_INNER;
        end
      end
      default: kind = FK_NONE;
    endcase
    if (kind == FK_COMMON || kind == FK_INNER) begin
      a = 3 * (q0 - p0);
      if (kind == FK_COMMON) a += sat8(p1 - q1);
      a = sat8(a);
      f1 = (a + 4 > 127 ? 127 : a + 4) >>> 3;
      f2 = (a + 3 > 127 ? 127 : a + 3) >>> 3;
      o_p0 = clamp_pix(p0 + f2);
      o_q0 = clamp_pix(q0 - f1);
      if (kind == FK_INNER) begin
        t = (f1 + 1) >>> 1;
        o_p1 = clamp_pix(p1 + t);
        o_q1 = clamp_pix(q1 - t);
      end
    end else if (kind == FK_WIDE) begin
      wv = sat8(sat8(p1 - q1) + 3 * (q0 - p0));
      a0 = (WIDE_TAP0 * wv + WIDE_ROUND) >>> 7;
      a1 = (WIDE_TAP1 * wv + WIDE_ROUND) >>> 7;
      a2 = (WIDE_TAP2 * wv + WIDE_ROUND) >>> 7;
      o_p2 = clamp_pix(p2 + a2);
      o_p1 = clamp_pix(p1 + a1);
      o_p0 = clamp_pix(p0 + a0);
      o_q0 = clamp_pix(q0 - a0);
      o_q1 = clamp_pix(q1 - a1);
      o_q2 = clamp_pix(q2 - a2);
    end
    r.pix = {pixel_t'(o_p2), pixel_t'(o_p1), pixel_t'(o_p0),
             pixel_t'(o_q0), pixel_t'(o_q1), pixel_t'(o_q2)};
    r.filtered = (kind != FK_NONE);
    return r;
  endfunction

  function automatic int pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly within the span, sometimes just beyond it
  function automatic int jitter(int span);
    if ($urandom_range(9) != 0) return int'($urandom_range(0, 2 * span)) - span;
    return ($urandom_range(1) ? 1 : -1) * (span + 1 + int'($urandom_range(3)));
  endfunction

  task automatic add_segment(opcode_t op, logic [63:0] px);
    word_queue.push_back('{op: op, pix: px});
  endtask

  task automatic queue_segments(int n);
    seg_word_t w;
    int unsigned style;
    repeat (n) begin
      style = $urandom_range(99);
      w.op = ($urandom_range(9) == 0) ? OP_UNUSED : opcode_t'($urandom_range(2));
      if (style < 75) begin
        w.pix[4] = pixel_t'($urandom_range(255));
        w.pix[3] = pixel_t'(clamp_pix(int'(w.pix[4]) + jitter(int'(edge_lim) / 3 + 1)));
        for (int i = 5; i < 8; i++)
          w.pix[i] = pixel_t'(clamp_pix(int'(w.pix[i-1]) + jitter(int_lim)));
        for (int i = 2; i >= 0; i--)
          w.pix[i] = pixel_t'(clamp_pix(int'(w.pix[i+1]) + jitter(int_lim)));
      end else if (style < 90) begin
        w.pix = {$urandom(), $urandom()};
      end else begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(2))
            0: w.pix[i] = 8'h00;
            1: w.pix[i] = 8'hFF;
            default: w.pix[i] = pixel_t'($urandom_range(255));
          endcase
        end
      end
      word_queue.push_back(w);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (word_queue.size() != 0 || seg_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(reg_index_t idx, int unsigned value);
    int unsigned w = (idx == REG_EDGE_LIMIT) ? 8 : 6;
    logic [31:0] raw;
    logic [ADDR_W-1:0] addr;
    raw = ($urandom() << w) | value;
    addr = {idx, 2'b00};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= raw;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_EDGE_LIMIT:     edge_lim = value;
      REG_INTERIOR_LIMIT: int_lim = value;
      default:            hev_thr = value;
    endcase
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: limit %0d readback expected %0d got %0d", $time, idx, value, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // segment driver
  always @(posedge clk) begin
    if (rst) begin
      seg_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) expected_results.push_back(filter_segment(cur_word));
      if (!seg_ch.valid || seg_ch.ready) begin
        if (src_gap > 0 || word_queue.size() == 0) begin
          seg_ch.valid <= 1'b0;
          if (src_gap > 0) src_gap <= src_gap - 1;
        end else begin
          cur_word = word_queue.pop_front();
          seg_ch.valid <= 1'b1;
          seg_ch.opcode <= cur_word.op;
          seg_ch.p3_in <= cur_word.pix[7];
          seg_ch.p2_in <= cur_word.pix[6];
          seg_ch.p1_in <= cur_word.pix[5];
          seg_ch.p0_in <= cur_word.pix[4];
          seg_ch.q0_in <= cur_word.pix[3];
          seg_ch.q1_in <= cur_word.pix[2];
          seg_ch.q2_in <= cur_word.pix[1];
          seg_ch.q3_in <= cur_word.pix[0];
          src_gap <= pick_gap(src_steady);
        end
      end
    end
  end

  // result monitor and ready pacing
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.pix = {res_ch.p2_out, res_ch.p1_out, res_ch.p0_out,
                   res_ch.q0_out, res_ch.q1_out, res_ch.q2_out};
        got.filtered = res_ch.was_filtered;
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got.pix[i] !== want.pix[i]) begin
              $display("%0t: %s_out expected %0d got %0d", $time, PIX_NAME[i],
                       want.pix[i], got.pix[i]);
              mismatches++;
            end
          end
          if (got.filtered !== want.filtered) begin
            $display("%0t: was_filtered expected %0d got %0d", $time,
                     want.filtered, got.filtered);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
        res_ch.ready <= 1'b0;
        hold_left <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (snk_steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4: begin
            res_ch.ready <= 1'b0;
            hold_left <= $urandom_range(0, 2);
          end
          5: begin
            res_ch.ready <= 1'b0;
            hold_left <= $urandom_range(8, 30);
          end
          default: res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("edge_loop_filter_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seg_ch.valid = 1'b0;
    seg_ch.opcode = OP_SIMPLE;
    {seg_ch.p3_in, seg_ch.p2_in, seg_ch.p1_in, seg_ch.p0_in} = '0;
    {seg_ch.q0_in, seg_ch.q1_in, seg_ch.q2_in, seg_ch.q3_in} = '0;
    res_ch.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    long_hold_req = 1'b0;
    long_hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    queue_segments(80);
    wait_drained();

    write_limit(REG_EDGE_LIMIT, 255);
    write_limit(REG_INTERIOR_LIMIT, 63);
    write_limit(REG_VAR_THRESHOLD, 8);
    // flat segment on every edge kind
    add_segment(OP_SIMPLE, 64'h80808080_80808080);
    add_segment(OP_MB_EDGE, 64'h80808080_80808080);
    add_segment(OP_INNER, 64'h80808080_80808080);
    add_segment(OP_UNUSED, 64'h80808080_80808080);
    add_segment(OP_MB_EDGE, 64'h00000000_00000000);
    add_segment(OP_INNER, 64'hFFFFFFFF_FFFFFFFF);
    // steep ramp, high variance
    add_segment(OP_SIMPLE, 64'h0A141E28_646E7882);
    add_segment(OP_MB_EDGE, 64'h0A141E28_646E7882);
    add_segment(OP_INNER, 64'h0A141E28_646E7882);
    // gentle ramps up and down, wide and inner filters
    add_segment(OP_MB_EDGE, 64'h282C3034_5C606468);
    add_segment(OP_INNER, 64'h282C3034_5C606468);
    add_segment(OP_MB_EDGE, 64'hF0ECE8E4_AAA6A29E);
    add_segment(OP_INNER, 64'hF0ECE8E4_AAA6A29E);
    // step that saturates the filter value
    add_segment(OP_SIMPLE, 64'h00000000_64646464);
    add_segment(OP_MB_EDGE, 64'h00000000_64646464);
    add_segment(OP_INNER, 64'h00000000_64646464);
    // edge limit fails
    add_segment(OP_SIMPLE, 64'h00000000_FFFFFFFF);
    add_segment(OP_MB_EDGE, 64'h00000000_FFFFFFFF);
    // interior limit fails at the outer pixels
    add_segment(OP_MB_EDGE, 64'h782C3034_5C606468);
    add_segment(OP_INNER, 64'h282C3034_5C6064F0);
    // high variance on one side only
    add_segment(OP_MB_EDGE, 64'h282C3034_5C707478);
    add_segment(OP_INNER, 64'h282C2034_5C606468);
    add_segment(OP_UNUSED, 64'h0A141E28_646E7882);
    queue_segments(200);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(REG_EDGE_LIMIT,
                  LIMIT_SETS[ph][0] < 0 ? $urandom_range(255) : LIMIT_SETS[ph][0]);
      write_limit(REG_INTERIOR_LIMIT,
                  LIMIT_SETS[ph][1] < 0 ? $urandom_range(63) : LIMIT_SETS[ph][1]);
      write_limit(REG_VAR_THRESHOLD,
                  LIMIT_SETS[ph][2] < 0 ? $urandom_range(63) : LIMIT_SETS[ph][2]);
      src_steady = (ph == 2 || ph == 3);
      snk_steady = (ph == 3);
      queue_segments(205);
      if (ph == 2) long_hold_req = 1'b1;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("edge_loop_filter_core: match");
    end else begin
      $display("edge_loop_filter_core: mismatch");
    end
    $finish;
  end

endmodule
